### hdl/line_edit_buffer_unit_assert.svh
// Assertion macros for the line edit buffer RTL.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef LINE_EDIT_BUFFER_UNIT_ASSERT_SVH
`define LINE_EDIT_BUFFER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define LEDB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("line edit buffer check failed");
`define LEDB_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define LEDB_ASSERT(lbl, prop)
`define LEDB_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

### hdl/ledb_pkg.sv
// Shared types and constants of the line edit buffer.
// No dependencies; used by the text memory and the top level.
`default_nettype none

package ledb_pkg;

  localparam int unsigned CHAR_W = 16;

  localparam logic [2:0] CMD_INSERT    = 3'd0;
  localparam logic [2:0] CMD_LEFT      = 3'd1;
  localparam logic [2:0] CMD_RIGHT     = 3'd2;
  localparam logic [2:0] CMD_BACKSPACE = 3'd3;
  localparam logic [2:0] CMD_DELETE    = 3'd4;
  localparam logic [2:0] CMD_CLEAR     = 3'd5;
  localparam logic [2:0] CMD_READ      = 3'd6;

  localparam logic [CHAR_W-1:0] CHAR_MIN = 16'd32;
  localparam logic [CHAR_W-1:0] CHAR_DEL = 16'd127;

  typedef struct packed {
    logic [2:0]        command;
    logic [CHAR_W-1:0] character;
    logic [7:0]        index;
  } cmd_word_t;

  typedef struct packed {
    logic              applied;
    logic [8:0]        cursor;
    logic [8:0]        length;
    logic [CHAR_W-1:0] read_char;
  } rsp_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHR,
    S_SHL,
    S_PUT,
    S_RDW,
    S_FIN
  } ledb_state_e;

endpackage

`default_nettype wire

### hdl/ledb_stream_if.sv
// Valid/ready stream interface carrying one word of a given payload type.
// Depends on nothing; instantiated with types from ledb_pkg.
`default_nettype none

interface ledb_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/line_edit_buffer_unit.sv
// Line edit buffer top level: command sequencer, cursor and length state.
// Depends on ledb_pkg, ledb_stream_if, ledb_text_mem and the assertion header.
//
// Each command word on cmd_i yields exactly one response word on rsp_o.
// Commands: insert, left, right, backspace, delete, clear and read. A
// response carries the applied flag, the cursor, the length and, for a
// successful read, the stored character.
// Insert and removal move the characters after the cursor one place at a
// time through the memory's read and write ports, one character per cycle.
// An insert shifts them up and then writes the new character, backspace and
// delete shift them down, a read waits for the registered memory read, and
// every command ends in a final step that updates the cursor and length and
// loads the response. cmd_i is ready only while the sequencer is idle, so
// one command is in work at a time and the next one can be accepted in the
// cycle after the previous one finishes, while its response may still wait
// in the output register. If rsp_o stalls, the sequencer holds the finished
// command in its final step until the output register frees up. Reset
// empties the buffer and sets the cursor to zero; the memory itself is not
// cleared.
`default_nettype none

module line_edit_buffer_unit #(
  parameter int unsigned MAX_LEN = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  ledb_stream_if.sink     cmd_i,
  ledb_stream_if.source   rsp_o
);

  import ledb_pkg::*;

  `include "line_edit_buffer_unit_assert.svh"

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = (LW > 8) ? LW : 8;

  ledb_state_e       state_q, state_d;
  logic [LW-1:0]     cur_q, cur_d;
  logic [LW-1:0]     len_q, len_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [2:0]        cmd_q, cmd_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              ok_q, ok_d;
  logic              wr_en_q, wr_en_d;
  logic [AW-1:0]     wr_addr_q, wr_addr_d;
  logic              wr_char_q, wr_char_d;
  logic              out_valid_q, out_valid_d;
  rsp_word_t         out_q, out_d;
  logic [CHAR_W-1:0] rdata;
  logic [CHAR_W-1:0] wdata;
  logic              ch_ok;

  assign wdata = wr_char_q ? char_q : rdata;

  ledb_text_mem #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en_q),
    .waddr_i (wr_addr_q),
    .wdata_i (wdata),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  assign cmd_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  assign ch_ok = (cmd_i.data.character >= CHAR_MIN) && (cmd_i.data.character != CHAR_DEL);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    len_d       = len_q;
    ptr_d       = ptr_q;
    cmd_d       = cmd_q;
    char_d      = char_q;
    ok_d        = ok_q;
    wr_en_d     = 1'b0;
    wr_addr_d   = wr_addr_q;
    wr_char_d   = 1'b0;
    out_valid_d = out_valid_q & ~rsp_o.ready;
    out_d       = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d   = cmd_i.data.command;
          char_d  = cmd_i.data.character;
          ok_d    = 1'b0;
          state_d = S_FIN;
          unique case (cmd_i.data.command)
            CMD_INSERT: begin
              if (ch_ok && (len_q != LW'(MAX_LEN))) begin
                ok_d = 1'b1;
                if (len_q == cur_q) begin
                  state_d = S_PUT;
                end else begin
                  ptr_d   = AW'(len_q - LW'(1));
                  state_d = S_SHR;
                end
              end
            end
            CMD_LEFT: begin
              ok_d = (cur_q != '0);
            end
            CMD_RIGHT: begin
              ok_d = (cur_q != len_q);
            end
            CMD_BACKSPACE: begin
              ok_d = (cur_q != '0);
              if ((cur_q != '0) && (cur_q < len_q)) begin
                ptr_d   = AW'(cur_q);
                state_d = S_SHL;
              end
            end
            CMD_DELETE: begin
              ok_d = (cur_q != len_q);
              if ((cur_q + LW'(1)) < len_q) begin
                ptr_d   = AW'(cur_q + LW'(1));
                state_d = S_SHL;
              end
            end
            CMD_CLEAR: begin
              ok_d = 1'b1;
            end
            CMD_READ: begin
              ok_d    = (CW'(cmd_i.data.index) < CW'(len_q));
              ptr_d   = AW'(cmd_i.data.index);
              state_d = S_RDW;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      S_SHR: begin
        wr_en_d   = 1'b1;
        wr_addr_d = ptr_q + AW'(1);
        if (LW'(ptr_q) == cur_q) begin
          state_d = S_PUT;
        end else begin
          ptr_d = ptr_q - AW'(1);
        end
      end
      S_SHL: begin
        wr_en_d   = 1'b1;
        wr_addr_d = ptr_q - AW'(1);
        if (LW'(ptr_q) == (len_q - LW'(1))) begin
          state_d = S_FIN;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      S_PUT: begin
        wr_en_d   = 1'b1;
        wr_addr_d = AW'(cur_q);
        wr_char_d = 1'b1;
        state_d   = S_FIN;
      end
      S_RDW: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          if (ok_q) begin
            case (cmd_q)
              CMD_INSERT: begin
                cur_d = cur_q + LW'(1);
                len_d = len_q + LW'(1);
              end
              CMD_LEFT:      cur_d = cur_q - LW'(1);
              CMD_RIGHT:     cur_d = cur_q + LW'(1);
              CMD_BACKSPACE: begin
                cur_d = cur_q - LW'(1);
                len_d = len_q - LW'(1);
              end
              CMD_DELETE:    len_d = len_q - LW'(1);
              CMD_CLEAR: begin
                cur_d = '0;
                len_d = '0;
              end
              default: begin
                cur_d = cur_q;
              end
            endcase
          end
          out_d.applied   = ok_q;
          out_d.cursor    = 9'(cur_d);
          out_d.length    = 9'(len_d);
          out_d.read_char = (ok_q && (cmd_q == CMD_READ)) ? rdata : '0;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      len_q       <= '0;
      wr_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      len_q       <= len_d;
      wr_en_q     <= wr_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    cmd_q     <= cmd_d;
    char_q    <= char_d;
    ok_q      <= ok_d;
    wr_addr_q <= wr_addr_d;
    wr_char_q <= wr_char_d;
    out_q     <= out_d;
  end

  `LEDB_ASSERT_MSG(a_cur_le_len, cur_q <= len_q, "cursor beyond length")
  `LEDB_ASSERT_MSG(a_len_le_max, len_q <= LW'(MAX_LEN), "length beyond capacity")
  `LEDB_ASSERT(a_rsp_from_fin, $rose(out_valid_q) |-> $past(state_q == S_FIN))
  `LEDB_ASSERT(a_len_step, (len_q != $past(len_q)) |-> ((len_q == $past(len_q) + LW'(1)) || (len_q == $past(len_q) - LW'(1)) || (len_q == '0)))
  `LEDB_ASSERT(a_wr_in_edit, wr_en_q |-> ((state_q == S_SHR) || (state_q == S_SHL) || (state_q == S_PUT) || (state_q == S_FIN)))

endmodule

`default_nettype wire

### hdl/ledb_text_mem.sv
// Text store of the line edit buffer: one write port, one registered read port.
// Depends on ledb_pkg for the character width.
`default_nettype none

module ledb_text_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [ledb_pkg::CHAR_W-1:0] wdata_i,
  input  wire logic [AW-1:0]             raddr_i,
  output logic      [ledb_pkg::CHAR_W-1:0] rdata_o
);

  logic [ledb_pkg::CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
